/* hdl/phf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phf_pkg
// Shared widths, types and codes for the peak half-wave frequency block.
// ----------------------------------------------------------------------------
package phf_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int SMP_W       = 16;
    localparam int POS_W       = 13;              // window bounds and walk position
    localparam int CNT_W       = 14;              // step count of both walks
    localparam int SHIFT_W     = 4;
    localparam int FREQ_W      = 16;
    localparam int DVD_W       = 20;              // rate register * 10
    localparam int DSR_W       = CNT_W + 1;       // (count - 1) * 2
    localparam int STEP_W      = $clog2(DVD_W);
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef logic [SMP_W-1:0]   sample_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [FREQ_W-1:0]  freq_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [DVD_W-1:0]   dvd_t;
    typedef logic [DSR_W-1:0]   dsr_t;
    typedef logic [2:0]         reg_idx_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam reg_idx_t REG_MIDPOINT   = 3'd0;
    localparam reg_idx_t REG_ACC_SHIFT  = 3'd1;
    localparam reg_idx_t REG_VALID_PEAK = 3'd2;
    localparam reg_idx_t REG_CROSS_BACK = 3'd3;
    localparam reg_idx_t REG_CROSS_FWD  = 3'd4;
    localparam reg_idx_t REG_SMP_RATE   = 3'd5;

    localparam sample_t RST_MIDPOINT   = 16'd32768;
    localparam shift_t  RST_ACC_SHIFT  = 4'd0;
    localparam sample_t RST_VALID_PEAK = 16'd4;
    localparam sample_t RST_CROSS_BACK = 16'd2;
    localparam sample_t RST_CROSS_FWD  = 16'd2;
    localparam sample_t RST_SMP_RATE   = 16'd1024;

    localparam freq_t FREQ_MAX = '1;

endpackage
`default_nettype wire

/* hdl/phf_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phf_req_if
// Request channel: sample writes and frequency queries.
// ----------------------------------------------------------------------------
interface phf_req_if;

    logic              valid;
    logic              ready;
    logic              req_type;
    phf_pkg::idx_t     sample_index;
    phf_pkg::sample_t  sample_value;
    phf_pkg::idx_t     peak_index;
    phf_pkg::pos_t     window_start;
    phf_pkg::pos_t     window_end;

    modport source (
        output valid, req_type, sample_index, sample_value, peak_index,
               window_start, window_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, sample_index, sample_value, peak_index,
               window_start, window_end,
        output ready
    );

endinterface
`default_nettype wire

/* hdl/phf_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phf_res_if
// Result channel: one frequency per query.
// ----------------------------------------------------------------------------
interface phf_res_if;

    logic            valid;
    logic            ready;
    phf_pkg::freq_t  freq_tenths;

    modport source (
        output valid, freq_tenths,
        input  ready
    );

    modport sink (
        input  valid, freq_tenths,
        output ready
    );

endinterface
`default_nettype wire

/* hdl/peak_halfwave_frequency_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peak_halfwave_frequency_top
// Sample store with a peak walk sequencer that estimates half-wave frequency.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------
//  req      | in  | valid/ready            | req_type, sample_index, sample_value,
//           |     |                        | peak_index, window_start, window_end
//  res      | out | valid/ready            | freq_tenths
//  apb      | in  | psel/penable/pready    | paddr, pwdata, prdata
//
//  A sample write is accepted only while idle; writes may follow back to back.
//  A query reads the peak and tests it above, then below the midpoint; it then
//  walks back and forward from the peak, each step a store read and a compare
//  in the one-port store loop, then starts the bit-serial divider and waits.
//  Queries that fail the peak test or count fewer than two steps skip the divide.
//  Request ready is low from query transfer until the result is in the output
//  register; a stalled result holds while further writes are still accepted.
//  Reset idles control and sets config registers to defaults; the store is not cleared.
// ----------------------------------------------------------------------------
module peak_halfwave_frequency_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    phf_req_if.sink                          req,
    phf_res_if.source                        res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [phf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [phf_pkg::DATA_W-1:0]  pwdata,
    output logic [phf_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PEAK_RD  = 4'd1;
    localparam logic [3:0] ST_PEAK_HI  = 4'd2;
    localparam logic [3:0] ST_PEAK_LO  = 4'd3;
    localparam logic [3:0] ST_BACK_RD  = 4'd4;
    localparam logic [3:0] ST_BACK_EV  = 4'd5;
    localparam logic [3:0] ST_FWD_RD   = 4'd6;
    localparam logic [3:0] ST_FWD_EV   = 4'd7;
    localparam logic [3:0] ST_DIV_GO   = 4'd8;
    localparam logic [3:0] ST_DIV_WAIT = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    // configuration registers
    phf_pkg::sample_t  mid_reg, vpk_reg, cbk_reg, cfw_reg, rate_reg;
    phf_pkg::shift_t   shift_reg;

    logic              cfg_wr;
    phf_pkg::reg_idx_t cfg_idx;

    // sample store
    phf_pkg::sample_t  mem [phf_pkg::STORE_DEPTH];
    phf_pkg::sample_t  rdata_reg;
    logic              wr_en;

    // sequencer
    logic [3:0]        state_reg, state_next;
    phf_pkg::pos_t     pos_reg, pos_next;
    phf_pkg::idx_t     peak_reg, peak_next;
    phf_pkg::pos_t     ws_reg, ws_next;
    phf_pkg::pos_t     we_reg, we_next;
    phf_pkg::cnt_t     cnt_reg, cnt_next;
    logic              high_reg, high_next;
    phf_pkg::freq_t    result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    phf_pkg::freq_t    out_data_reg, out_data_next;

    // shared compare unit
    logic [2:0]        half_shift;
    phf_pkg::sample_t  th_sel;
    logic              hi_sel;
    logic [phf_pkg::SMP_W:0] bound_hi;
    logic [phf_pkg::SMP_W:0] smp_plus_th;
    logic              hit;

    logic              back_ok, fwd_ok;
    logic              query_xfer, load_out;

    phf_pkg::cnt_t     cnt_m1;
    phf_pkg::dvd_t     dividend;
    phf_pkg::dsr_t     divisor;
    logic              div_start, div_done;
    phf_pkg::dvd_t     quotient;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg   <= phf_pkg::RST_MIDPOINT;
            shift_reg <= phf_pkg::RST_ACC_SHIFT;
            vpk_reg   <= phf_pkg::RST_VALID_PEAK;
            cbk_reg   <= phf_pkg::RST_CROSS_BACK;
            cfw_reg   <= phf_pkg::RST_CROSS_FWD;
            rate_reg  <= phf_pkg::RST_SMP_RATE;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                phf_pkg::REG_MIDPOINT:   mid_reg   <= pwdata[phf_pkg::SMP_W-1:0];
                phf_pkg::REG_ACC_SHIFT:  shift_reg <= pwdata[phf_pkg::SHIFT_W-1:0];
                phf_pkg::REG_VALID_PEAK: vpk_reg   <= pwdata[phf_pkg::SMP_W-1:0];
                phf_pkg::REG_CROSS_BACK: cbk_reg   <= pwdata[phf_pkg::SMP_W-1:0];
                phf_pkg::REG_CROSS_FWD:  cfw_reg   <= pwdata[phf_pkg::SMP_W-1:0];
                phf_pkg::REG_SMP_RATE:   rate_reg  <= pwdata[phf_pkg::SMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            phf_pkg::REG_MIDPOINT:   prdata = phf_pkg::DATA_W'(mid_reg);
            phf_pkg::REG_ACC_SHIFT:  prdata = phf_pkg::DATA_W'(shift_reg);
            phf_pkg::REG_VALID_PEAK: prdata = phf_pkg::DATA_W'(vpk_reg);
            phf_pkg::REG_CROSS_BACK: prdata = phf_pkg::DATA_W'(cbk_reg);
            phf_pkg::REG_CROSS_FWD:  prdata = phf_pkg::DATA_W'(cfw_reg);
            phf_pkg::REG_SMP_RATE:   prdata = phf_pkg::DATA_W'(rate_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- sample store ----------------
    assign req.ready  = (state_reg == ST_IDLE);
    assign wr_en      = req.valid && req.ready && (req.req_type == phf_pkg::REQ_WRITE);
    assign query_xfer = req.valid && req.ready && (req.req_type == phf_pkg::REQ_QUERY);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[req.sample_index] <= req.sample_value;
        end
        rdata_reg <= mem[pos_reg[phf_pkg::IDX_W-1:0]];
    end

    // ---------------- shared compare ----------------
    assign half_shift = shift_reg[phf_pkg::SHIFT_W-1:1];

    always_comb
    begin
        case (state_reg)
            ST_PEAK_HI:
            begin
                th_sel = vpk_reg >> half_shift;
                hi_sel = 1'b1;
            end
            ST_PEAK_LO:
            begin
                th_sel = vpk_reg >> half_shift;
                hi_sel = 1'b0;
            end
            ST_BACK_EV:
            begin
                th_sel = cbk_reg >> half_shift;
                hi_sel = high_reg;
            end
            default:
            begin
                th_sel = cfw_reg >> half_shift;
                hi_sel = high_reg;
            end
        endcase
        bound_hi    = {1'b0, mid_reg} + {1'b0, th_sel};
        smp_plus_th = {1'b0, rdata_reg} + {1'b0, th_sel};
        // above: s >= mid + th; below: s + th <= mid
        if (hi_sel)
        begin
            hit = ({1'b0, rdata_reg} >= bound_hi);
        end
        else
        begin
            hit = (smp_plus_th <= {1'b0, mid_reg});
        end
    end

    assign back_ok = {1'b0, pos_reg} > ({1'b0, ws_reg} + 14'd1);
    assign fwd_ok  = ({1'b0, pos_reg} + 14'd1) < {1'b0, we_reg};

    // ---------------- divider ----------------
    assign cnt_m1    = cnt_reg - 1'b1;
    assign divisor   = {cnt_m1, 1'b0};
    assign dividend  = ({4'b0000, rate_reg} << 3) + ({4'b0000, rate_reg} << 1);
    assign div_start = (state_reg == ST_DIV_GO) && (cnt_reg[phf_pkg::CNT_W-1:1] != '0);

    phf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- sequencer ----------------
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        peak_next      = peak_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        cnt_next       = cnt_reg;
        high_next      = high_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    peak_next  = req.peak_index;
                    pos_next   = {1'b0, req.peak_index};
                    ws_next    = req.window_start;
                    we_next    = req.window_end;
                    cnt_next   = '0;
                    state_next = ST_PEAK_RD;
                end
            end
            ST_PEAK_RD:
            begin
                state_next = ST_PEAK_HI;
            end
            ST_PEAK_HI:
            begin
                if (hit)
                begin
                    high_next  = 1'b1;
                    state_next = ST_BACK_EV;
                end
                else
                begin
                    state_next = ST_PEAK_LO;
                end
            end
            ST_PEAK_LO:
            begin
                if (hit)
                begin
                    high_next  = 1'b0;
                    state_next = ST_BACK_EV;
                end
                else
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_BACK_RD:
            begin
                state_next = ST_BACK_EV;
            end
            ST_BACK_EV:
            begin
                if (hit && back_ok)
                begin
                    pos_next   = pos_reg - 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_BACK_RD;
                end
                else
                begin
                    // restart from the peak going forward
                    pos_next   = {1'b0, peak_reg};
                    state_next = ST_FWD_RD;
                end
            end
            ST_FWD_RD:
            begin
                state_next = ST_FWD_EV;
            end
            ST_FWD_EV:
            begin
                if (hit && fwd_ok)
                begin
                    pos_next   = pos_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_FWD_RD;
                end
                else
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    // saturate quotient to the output width
                    if (quotient[phf_pkg::DVD_W-1:phf_pkg::FREQ_W] != '0)
                    begin
                        result_next = phf_pkg::FREQ_MAX;
                    end
                    else
                    begin
                        result_next = quotient[phf_pkg::FREQ_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        peak_reg     <= peak_next;
        ws_reg       <= ws_next;
        we_reg       <= we_next;
        cnt_reg      <= cnt_next;
        high_reg     <= high_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.freq_tenths = out_data_reg;

endmodule
`default_nettype wire

/* hdl/phf_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phf_div
// Restoring divider, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
module phf_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire phf_pkg::dvd_t     dividend,
    input  wire phf_pkg::dsr_t     divisor,
    output logic                   done,
    output phf_pkg::dvd_t          quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [phf_pkg::STEP_W-1:0]    step_reg, step_next;
    phf_pkg::dvd_t                 dvd_reg, dvd_next;
    phf_pkg::dsr_t                 rem_reg, rem_next;
    phf_pkg::dsr_t                 dsr_reg, dsr_next;

    logic [phf_pkg::DSR_W:0]       shifted;
    logic [phf_pkg::DSR_W+1:0]     diff;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[phf_pkg::DVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (!diff[phf_pkg::DSR_W+1])
            begin
                rem_next = diff[phf_pkg::DSR_W-1:0];
                dvd_next = {dvd_reg[phf_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[phf_pkg::DSR_W-1:0];
                dvd_next = {dvd_reg[phf_pkg::DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == phf_pkg::STEP_W'(phf_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire
